FILE: hdl/pdsi_pkg.sv
// ----------------------------------------------------------------------------
// Plane distance / segment intersection package
// Shared constants, codes and the control record that travels down the
// divider chain.
// ----------------------------------------------------------------------------
package pdsi_pkg;

  // Default geometry widths.
  localparam int COORD_WIDTH_DEF      = 32;
  localparam int NORMAL_FRAC_BITS_DEF = 14;

  // The intersection parameter is signed Q1.16 and is emitted as an 18-bit signed field.
  localparam int T_FRAC  = 16;
  localparam int T_WIDTH = 18;
  // Quotient register width: the integer part (up to 2), 16 fraction bits and the
  // rounding carry.
  localparam int Q_WIDTH = T_FRAC + 3;
  // Largest and smallest t that still counts as a hit (one LSB outside 0..1).
  localparam logic [Q_WIDTH-1:0] T_POS_LIMIT = Q_WIDTH'((1 << T_FRAC) + 1);
  localparam logic [Q_WIDTH-1:0] T_NEG_LIMIT = Q_WIDTH'(1);

  // Operation codes.
  localparam logic OP_DIST = 1'b0;
  localparam logic OP_SEG  = 1'b1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_NORMAL_X     = 2'd0,
    REG_NORMAL_Y     = 2'd1,
    REG_NORMAL_Z     = 2'd2,
    REG_PLANE_OFFSET = 2'd3
  } reg_idx_t;

  // Control record carried alongside each item in the divider chain.
  typedef struct packed {
    logic valid;
    logic behind;
    logic ok;    // Segment item with a usable division.
    logic neg;   // Quotient sign.
  } ctrl_t;

endpackage

FILE: hdl/pdsi_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step: it develops one quotient bit and hands the
// partial remainder, the divisor and the item's other fields to the next cell.
// ----------------------------------------------------------------------------
module pdsi_div_cell #(
  parameter int DW = 50,
  parameter int CW = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  pdsi_pkg::ctrl_t                 in_ctrl,
  input  logic [CW-1:0]                   in_dist,
  input  logic [pdsi_pkg::Q_WIDTH-1:0]    in_quo,
  input  logic [DW-1:0]                   in_rem,
  input  logic [DW-1:0]                   in_den,
  output pdsi_pkg::ctrl_t                 out_ctrl,
  output logic [CW-1:0]                   out_dist,
  output logic [pdsi_pkg::Q_WIDTH-1:0]    out_quo,
  output logic [DW-1:0]                   out_rem,
  output logic [DW-1:0]                   out_den
);
  import pdsi_pkg::*;

  logic [DW:0]        rem2;
  logic               take;
  logic [DW-1:0]      rem_nxt;
  logic [Q_WIDTH-1:0] quo_nxt;
  ctrl_t              ctrl_r;
  logic [CW-1:0]      dist_r;
  logic [Q_WIDTH-1:0] quo_r;
  logic [DW-1:0]      rem_r;
  logic [DW-1:0]      den_r;

  // Shift the remainder and subtract the divisor where it fits.
  always_comb begin
    rem2    = {in_rem, 1'b0};
    take    = (rem2 >= {1'b0, in_den});
    rem_nxt = take ? DW'(rem2 - {1'b0, in_den}) : rem2[DW-1:0];
    quo_nxt = {in_quo[Q_WIDTH-2:0], take};
  end

  // Control is reset; the payload needs none.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else if (en) begin
      ctrl_r <= in_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= in_dist;
      quo_r  <= quo_nxt;
      rem_r  <= rem_nxt;
      den_r  <= in_den;
    end
  end

  assign out_ctrl = ctrl_r;
  assign out_dist = dist_r;
  assign out_quo  = quo_r;
  assign out_rem  = rem_r;
  assign out_den  = den_r;

endmodule

FILE: hdl/plane_distance_segment_intersect_core.sv
// ----------------------------------------------------------------------------
// Plane distance and segment intersection core
// Signed point-to-plane distance and segment/plane intersection parameter
// against a plane held in configuration registers.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake          | Contents
//  in_      | input     | in_valid/in_ready  | op, segment start, direction
//  out_     | output    | out_valid/out_ready| distance, behind, hit, t
//  cfg_     | input     | cfg_we             | normal x/y/z, plane offset
//
// One item is accepted per cycle while the pipeline is not held; each result passes
// through three arithmetic stages, a chain of 16 divider cells and the output register.
// The whole pipeline advances together and holds while a result waits.
// Reset is synchronous; it clears the valid bits and sets the plane to normal (0, 0, 1), offset 0.
// ----------------------------------------------------------------------------
module plane_distance_segment_intersect_core #(
  parameter int COORD_WIDTH      = pdsi_pkg::COORD_WIDTH_DEF,
  parameter int NORMAL_FRAC_BITS = pdsi_pkg::NORMAL_FRAC_BITS_DEF,
  localparam int NW   = NORMAL_FRAC_BITS + 2,
  localparam int CFGW = (COORD_WIDTH > NW) ? COORD_WIDTH : NW
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_op,
  input  logic signed [COORD_WIDTH-1:0]      in_start_x,
  input  logic signed [COORD_WIDTH-1:0]      in_start_y,
  input  logic signed [COORD_WIDTH-1:0]      in_start_z,
  input  logic signed [COORD_WIDTH-1:0]      in_dir_x,
  input  logic signed [COORD_WIDTH-1:0]      in_dir_y,
  input  logic signed [COORD_WIDTH-1:0]      in_dir_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [COORD_WIDTH-1:0]      out_signed_distance,
  output logic                               out_behind,
  output logic                               out_hit,
  output logic signed [pdsi_pkg::T_WIDTH-1:0] out_t_param,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [CFGW-1:0]                    cfg_wdata
);
  import pdsi_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int NF  = NORMAL_FRAC_BITS;
  localparam int PW  = CW + NW;       // one product
  localparam int DW  = PW + 2;        // sum of three products
  localparam int XW  = DW + 2;        // difference with the offset
  localparam int AW  = DW + 3;        // signed numerator after sign fix
  localparam logic signed [XW-1:0] DMAX = {{(XW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [XW-1:0] DMIN = ~DMAX;
  localparam logic signed [XW-1:0] HALF = XW'(1) <<< (NF - 1);

  // Plane registers.
  logic signed [NW-1:0] normal_x_r, normal_y_r, normal_z_r;
  logic signed [CW-1:0] plane_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normal_x_r     <= '0;
      normal_y_r     <= '0;
      normal_z_r     <= NW'(1) << NF;
      plane_offset_r <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_NORMAL_X:     normal_x_r     <= cfg_wdata[NW-1:0];
        REG_NORMAL_Y:     normal_y_r     <= cfg_wdata[NW-1:0];
        REG_NORMAL_Z:     normal_z_r     <= cfg_wdata[NW-1:0];
        REG_PLANE_OFFSET: plane_offset_r <= cfg_wdata[CW-1:0];
        default:          ;
      endcase
    end
  end

  // The whole pipeline moves when the output register is free.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage 1: the six products.
  logic                 s1_valid_r, s1_op_r;
  logic signed [PW-1:0] ps_x_r, ps_y_r, ps_z_r, pv_x_r, pv_y_r, pv_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op_r <= in_op;
      ps_x_r  <= PW'(normal_x_r) * PW'(in_start_x);
      ps_y_r  <= PW'(normal_y_r) * PW'(in_start_y);
      ps_z_r  <= PW'(normal_z_r) * PW'(in_start_z);
      pv_x_r  <= PW'(normal_x_r) * PW'(in_dir_x);
      pv_y_r  <= PW'(normal_y_r) * PW'(in_dir_y);
      pv_z_r  <= PW'(normal_z_r) * PW'(in_dir_z);
    end
  end

  // Stage 2: dot products and the distance numerator n.s - d.
  logic signed [XW-1:0] off30;
  logic signed [XW-1:0] dot_s;
  logic signed [DW-1:0] dot_v;
  logic                 s2_valid_r, s2_op_r;
  logic signed [XW-1:0] diff_r;
  logic signed [DW-1:0] den_r;

  always_comb begin
    off30 = XW'(plane_offset_r) <<< NF;
    dot_s = XW'(ps_x_r) + XW'(ps_y_r) + XW'(ps_z_r);
    dot_v = DW'(pv_x_r) + DW'(pv_y_r) + DW'(pv_z_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_op_r <= s1_op_r;
      diff_r  <= dot_s - off30;
      den_r   <= dot_v;
    end
  end

  // Stage 3: rounded and saturated distance; divider set-up.
  logic signed [XW-1:0] dist_sh;
  logic signed [XW-1:0] dist_sat;
  logic signed [DW:0]   den_e;
  logic [DW-1:0]        ad;
  logic signed [AW-1:0] num;
  logic [AW-1:0]        an;
  logic [AW-1:0]        ad_e, ad2_e;
  logic                 num_neg, in_range;
  logic [1:0]           q0;
  logic [AW-1:0]        r0;
  ctrl_t                c3;
  logic [CW-1:0]        d3;

  always_comb begin
    dist_sh  = (diff_r + HALF) >>> NF;
    dist_sat = (dist_sh > DMAX) ? DMAX : ((dist_sh < DMIN) ? DMIN : dist_sh);
    den_e    = (DW+1)'(den_r);
    ad       = den_r[DW-1] ? DW'(-den_e) : DW'(den_e);
    // num = d - n.s, negated together with a negative denominator.
    num      = den_r[DW-1] ? AW'(diff_r) : -AW'(diff_r);
    num_neg  = num[AW-1];
    an       = num_neg ? AW'(-num) : AW'(num);
    ad_e     = AW'(ad);
    ad2_e    = ad_e << 1;
    in_range = (an <= ad2_e);
    if (an >= ad2_e) begin
      q0 = 2'd2;
      r0 = an - ad2_e;
    end else if (an >= ad_e) begin
      q0 = 2'd1;
      r0 = an - ad_e;
    end else begin
      q0 = 2'd0;
      r0 = an;
    end
    c3.valid  = s2_valid_r;
    c3.behind = (s2_op_r == OP_DIST) && dist_sat[XW-1];
    c3.ok     = (s2_op_r == OP_SEG) && (den_r != '0) && in_range;
    c3.neg    = num_neg;
    d3        = (s2_op_r == OP_DIST) ? dist_sat[CW-1:0] : '0;
  end

  // Head of the divider chain.
  ctrl_t              ch_ctrl [0:T_FRAC];
  logic [CW-1:0]      ch_dist [0:T_FRAC];
  logic [Q_WIDTH-1:0] ch_quo  [0:T_FRAC];
  logic [DW-1:0]      ch_rem  [0:T_FRAC];
  logic [DW-1:0]      ch_den  [0:T_FRAC];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_ctrl[0] <= '0;
    end else if (en) begin
      ch_ctrl[0] <= c3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ch_dist[0] <= d3;
      ch_quo[0]  <= Q_WIDTH'(q0);
      ch_rem[0]  <= r0[DW-1:0];
      ch_den[0]  <= ad;
    end
  end

  // One cell per fraction bit of t.
  for (genvar i = 0; i < T_FRAC; i++) begin : g_cell
    pdsi_div_cell #(
      .DW (DW),
      .CW (CW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_ctrl  (ch_ctrl[i]),
      .in_dist  (ch_dist[i]),
      .in_quo   (ch_quo[i]),
      .in_rem   (ch_rem[i]),
      .in_den   (ch_den[i]),
      .out_ctrl (ch_ctrl[i+1]),
      .out_dist (ch_dist[i+1]),
      .out_quo  (ch_quo[i+1]),
      .out_rem  (ch_rem[i+1]),
      .out_den  (ch_den[i+1])
    );
  end

  // Final rounding, range check and output register.
  ctrl_t              cl;
  logic [DW:0]        rem_l2;
  logic [Q_WIDTH-1:0] qf;
  logic [Q_WIDTH-1:0] tq;
  logic               t_ok, hit_nxt;

  always_comb begin
    cl      = ch_ctrl[T_FRAC];
    rem_l2  = {ch_rem[T_FRAC], 1'b0};
    qf      = ch_quo[T_FRAC] + Q_WIDTH'(rem_l2 >= {1'b0, ch_den[T_FRAC]});
    t_ok    = cl.neg ? (qf <= T_NEG_LIMIT) : (qf <= T_POS_LIMIT);
    hit_nxt = cl.ok && t_ok;
    tq      = cl.neg ? -qf : qf;
  end

  logic                        out_valid_r, out_behind_r, out_hit_r;
  logic signed [CW-1:0]        out_dist_r;
  logic signed [T_WIDTH-1:0]   out_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= cl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_dist_r   <= ch_dist[T_FRAC];
      out_behind_r <= cl.behind;
      out_hit_r    <= hit_nxt;
      out_t_r      <= hit_nxt ? tq[T_WIDTH-1:0] : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_signed_distance = out_dist_r;
  assign out_behind          = out_behind_r;
  assign out_hit             = out_hit_r;
  assign out_t_param         = out_t_r;

  // A hit comes only from a segment item, which carries no distance.
  a_hit_no_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_behind && out_signed_distance == '0)
    else $error("hit result carries a distance");

  // A miss always reports a zero parameter.
  a_miss_zero_t: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_t_param == '0)
    else $error("miss with non-zero t");

  // The behind flag follows the sign of the saturated distance.
  a_behind_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_behind == out_signed_distance[CW-1])
    else $error("behind flag disagrees with distance sign");

endmodule
